// ===== design/strict_priority_ready_queue_core_assert.svh =====
// Assertion macros used by the ready queue core.
`ifndef STRICT_PRIORITY_READY_QUEUE_CORE_ASSERT_SVH
`define STRICT_PRIORITY_READY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Types, constants and helpers of the strict priority ready queue.
package spq_pkg;

  localparam int NUM_PRIO    = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int LVL_W  = $clog2(NUM_PRIO);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_PRIO * QUEUE_DEPTH);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] task_id;
    logic [2:0] prio;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] granted_task;
    logic [2:0] granted_prio;
  } out_word_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
  } store_req_t;

  // Flat store address of one slot of one level.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
    int unsigned a;
    a = int'(lvl) * QUEUE_DEPTH + int'(ptr);
    return ADDR_W'(a);
  endfunction

  // Advance a ring pointer, wrapping at the last slot.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ===== design/spq_store.sv =====
// Task store: one synchronous RAM holding the slots of every priority level.
module spq_store
  import spq_pkg::*;
(
  input  logic               clk,
  input  store_req_t         req,
  output logic [ID_BITS-1:0] rd_data
);

  logic [ID_BITS-1:0] mem [NUM_PRIO * QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/strict_priority_ready_queue_core.sv =====
// Strict priority ready queue: one FIFO of task ids per level, level 0 served first.
// An add word, and a take that finds every level empty, has its result registered in the
// output register or skid entry in the cycle after acceptance; a dispatching take is
// answered from S_READ, once the task id comes out of the shared task RAM's registered
// read, and the input is held off through S_READ. An output register plus one skid entry
// decouple the result side, so input keeps flowing while a result waits; the input stalls
// only when both hold a word or in S_READ. The task RAM needs no clearing pass after
// reset: per-level fill counts guard every read.
module strict_priority_ready_queue_core
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  `include "strict_priority_ready_queue_core_assert.svh"

  fsm_t state_r, state_nxt;

  logic [PTR_W-1:0] head_r [NUM_PRIO];
  logic [PTR_W-1:0] tail_r [NUM_PRIO];
  logic [CNT_W-1:0] cnt_r  [NUM_PRIO];
  logic [LVL_W-1:0] lvl_r;

  logic      out_valid_r, skid_v_r;
  out_word_t out_r, skid_r;

  logic               in_fire;
  logic [LVL_W-1:0]   in_lvl, take_lvl;
  logic               add_full, any_ne;
  logic               prod_v;
  out_word_t          prod;
  store_req_t         sreq;
  logic [ID_BITS-1:0] rd_data;
  logic               out_free;

  assign in_fire  = in_valid && in_ready;
  assign in_lvl   = LVL_W'(in_data.prio);
  assign add_full = (int'(in_data.prio) >= NUM_PRIO) ||
                    (cnt_r[in_lvl] == CNT_W'(QUEUE_DEPTH));

  // Lowest-numbered non-empty level wins.
  always_comb begin
    any_ne   = 1'b0;
    take_lvl = '0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        any_ne   = 1'b1;
        take_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.op == OP_TAKE && any_ne) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    prod_v       = 1'b0;
    prod         = '0;
    sreq         = '0;
    sreq.wr_addr = slot_addr(in_lvl, tail_r[in_lvl]);
    sreq.wr_data = ID_BITS'(in_data.task_id);
    sreq.rd_addr = slot_addr(take_lvl, head_r[take_lvl]);
    unique case (state_r)
      S_IDLE: begin
        in_ready = !skid_v_r;
        if (in_fire) begin
          if (in_data.op == OP_ADD) begin
            prod_v      = 1'b1;
            prod.status = add_full ? ST_FULL : ST_ADDED;
            sreq.wr_en  = !add_full;
          end else if (any_ne) begin
            sreq.rd_en = 1'b1;
          end else begin
            prod_v      = 1'b1;
            prod.status = ST_EMPTY;
          end
        end
      end
      S_READ: begin
        prod_v            = 1'b1;
        prod.status       = ST_DISPATCHED;
        prod.granted_task = 8'(rd_data);
        prod.granted_prio = 3'(lvl_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  spq_store u_store (
    .clk     (clk),
    .req     (sreq),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NUM_PRIO; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (sreq.wr_en) begin
        tail_r[in_lvl] <= ptr_inc(tail_r[in_lvl]);
        cnt_r[in_lvl]  <= cnt_r[in_lvl] + CNT_W'(1);
      end
      if (sreq.rd_en) begin
        head_r[take_lvl] <= ptr_inc(head_r[take_lvl]);
        cnt_r[take_lvl]  <= cnt_r[take_lvl] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sreq.rd_en) begin
      lvl_r <= take_lvl;
    end
  end

  // Output register with one skid entry behind it; the skid word is always newer.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= prod_v;
      end else begin
        out_valid_r <= prod_v;
      end
    end else if (prod_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_r  <= skid_r;
        skid_r <= prod;
      end else begin
        out_r <= prod;
      end
    end else if (prod_v) begin
      skid_r <= prod;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SPQ_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_valid_r,
    "skid holds a word while the output register is empty")
  `SPQ_ASSERT_NOW(a_read_skid_free, state_r == S_READ, !(skid_v_r && !out_free),
    "dispatch result arrives with nowhere to go")
  `SPQ_ASSERT_NEXT(a_dispatch_read, in_fire && in_data.op == OP_TAKE && any_ne,
    state_r == S_READ && out_valid_r == $past(out_valid_r && !out_ready),
    "dispatching take did not start a store read")
  `SPQ_ASSERT_NEXT(a_quick_result, in_fire && (in_data.op == OP_ADD || !any_ne),
    out_valid_r && state_r == S_IDLE, "add or empty take gave no result")

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the strict priority ready queue: random add/take traffic.
module testbench;
  import spq_pkg::*;

  typedef struct {
    in_word_t    word;
    int unsigned idle_after;
  } task_request_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  task_request_t      task_requests[$];
  out_word_t          expected_grants[$];
  logic [ID_BITS-1:0] ready_tasks[NUM_PRIO][$];

  int unsigned total_items = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned mode_left = 0;
  logic        stall_free = 1'b0;
  int unsigned backpressure_left = 0;
  int unsigned holds_done = 0;

  strict_priority_ready_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one word to the per-level task lists and return the word the queue must answer.
  function automatic out_word_t schedule_word(input in_word_t w);
    out_word_t          r;
    logic [ID_BITS-1:0] id;
    logic               found;
    r = '0;
    found = 1'b0;
    if (w.op == OP_ADD) begin
      if (int'(w.prio) >= NUM_PRIO || ready_tasks[w.prio].size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        ready_tasks[w.prio].push_back(w.task_id[ID_BITS-1:0]);
        r.status = ST_ADDED;
      end
    end else begin
      r.status = ST_EMPTY;
      for (int lvl = 0; lvl < NUM_PRIO; lvl++) begin
        if (!found && ready_tasks[lvl].size() != 0) begin
          id = ready_tasks[lvl].pop_front();
          r.status = ST_DISPATCHED;
          r.granted_task = 8'(id);
          r.granted_prio = 3'(lvl);
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s): expected status=%0d task=%h prio=%0d, got status=%0d task=%h prio=%0d",
               what, want.status, want.granted_task, want.granted_prio,
               got.status, got.granted_task, got.granted_prio);
    end
  endtask

  task automatic queue_request(input op_t op, input logic [7:0] id, input logic [2:0] lvl,
                               input int unsigned idle);
    task_request_t t;
    t.word.op      = op;
    t.word.task_id = id;
    t.word.prio    = lvl;
    t.idle_after   = idle;
    task_requests.push_back(t);
  endtask

  // Driver: present queued words, hold while stalled, idle between words.
  always @(posedge clk) begin
    task_request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_grants.push_back(schedule_word(in_data));
        accepted_count <= accepted_count + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the current word
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (task_requests.size() != 0) begin
        nxt = task_requests.pop_front();
        in_valid <= 1'b1;
        in_data  <= nxt.word;
        gap_left <= nxt.idle_after;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-offs so the queue fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      backpressure_left <= 0;
      holds_done <= 0;
    end else if (backpressure_left != 0) begin
      backpressure_left <= backpressure_left - 1;
    end else if (holds_done < 2 && accepted_count >= (holds_done + 1) * 150) begin
      backpressure_left <= 300;
      holds_done <= holds_done + 1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation, pace out_ready.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      mode_left  <= 0;
      stall_free <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          note_mismatch("no word expected", '0, out_data);
        end else begin
          want = expected_grants.pop_front();
          if (out_data.status !== want.status || out_data.granted_task !== want.granted_task ||
              out_data.granted_prio !== want.granted_prio) begin
            note_mismatch("field", want, out_data);
          end
        end
      end
      if (mode_left == 0) begin
        mode_left  <= $urandom_range(20, 120);
        stall_free <= ($urandom_range(0, 2) == 0);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (backpressure_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!stall_free && $urandom_range(0, 99) < 30) begin
        stall_left <= pick_gap();
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned seg_len;
    int unsigned add_pct;
    int unsigned idle;
    logic        focused;
    logic        steady;
    logic [2:0]  focus_lvl;
    logic [2:0]  lvl;
    op_t         op;

    // Take from an empty queue, then level ordering and id extremes.
    queue_request(OP_TAKE, 8'hFF, 3'd7, 0);
    queue_request(OP_ADD,  8'hFF, 3'd7, 0);
    queue_request(OP_ADD,  8'h00, 3'd0, 1);
    queue_request(OP_ADD,  8'hAA, 3'd3, 0);
    queue_request(OP_TAKE, 8'h00, 3'd0, 0);
    queue_request(OP_TAKE, 8'h55, 3'd5, 2);
    queue_request(OP_TAKE, 8'h00, 3'd0, 0);
    queue_request(OP_TAKE, 8'h00, 3'd0, 0);
    // Fill one level to the brim, then one add too many is refused.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_request(OP_ADD, 8'(i * 17), 3'd5, 0);
    end
    queue_request(OP_ADD, 8'h5A, 3'd5, 0);

    // Random segments lean towards filling, balance or draining, spread or on a pair of levels.
    while (task_requests.size() < 550) begin
      seg_len = $urandom_range(15, 60);
      case ($urandom_range(0, 2))
        0:       add_pct = 85;
        1:       add_pct = 50;
        default: add_pct = 15;
      endcase
      focused   = $urandom_range(0, 1);
      focus_lvl = 3'($urandom_range(0, NUM_PRIO - 1));
      steady    = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        op   = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TAKE;
        lvl  = focused ? (focus_lvl ^ 3'($urandom_range(0, 1))) : 3'($urandom_range(0, 7));
        idle = steady ? 0 : pick_gap();
        queue_request(op, 8'($urandom_range(0, 255)), lvl, idle);
      end
    end
    total_items = task_requests.size();

    while (accepted_count < total_items) @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/spq_pkg.sv
design/spq_store.sv
design/strict_priority_ready_queue_core.sv
dv/testbench.sv
